@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define IGPB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define IGPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/igpb_pkg.sv @@
`default_nettype none

package igpb_pkg;

  // default for the largest image side
  localparam int unsigned MAX_DIM_DEF = 4096;

  // configuration port shape
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLOW_RED      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLOW_GREEN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLOW_BLUE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GLOW_STRENGTH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_BLUR  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BLUR_CEILING  = 3'd7;

  // strength at full opacity
  localparam logic [8:0] STRENGTH_FULL = 9'd256;
  // 1.0 in the q.17 falloff term
  localparam logic [17:0] T_ONE = 18'h20000;
  // rounding term for the weight, half of 2^35
  localparam logic [42:0] K_ROUND = 43'h004_0000_0000;
  // largest weight the falloff can reach
  localparam logic [7:0] K_MAX = 8'd128;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [7:0]  glow_red;
    logic [7:0]  glow_green;
    logic [7:0]  glow_blue;
    logic [8:0]  glow_strength;
    logic [23:0] inverse_blur;
    logic [12:0] blur_ceiling;
  } cfg_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // geometry result: distance to nearest edge and band hit
  typedef struct packed {
    pix_t        pix;
    logic        glow;
    logic [11:0] edge_dist;
  } geo_t;

  // weight result: falloff weight, zero when no glow
  typedef struct packed {
    pix_t       pix;
    logic [7:0] k;
  } wt_t;

  function automatic logic [12:0] umin13(input logic [12:0] a, input logic [12:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/inset_glow_pixel_blend.sv @@
// inset edge glow on a stream of premultiplied argb pixels
//
// input channel: in_valid_i / in_stall_o carry one request per pixel with its
// column, row and four channels. output channel: out_valid_o / out_stall_i
// carry the pixel with the glow blended in; alpha passes through.
// configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is
// high; write only while no pixel is in flight.
//
// pipeline: from acceptance to out_valid_o a pixel passes 2 geometry stages,
// 4 weight stages with the q.17 falloff multiplies and 2 blend stages.
// throughput: one pixel per cycle while the output is not stalled; each stage holds one pixel.
// stall: a stalled output holds its pixel; upstream stages keep filling any
// empty slot, so in_stall_o rises only once all 8 stages are occupied.
// reset: all stages empty, image size 1x1, glow off (pixels pass unchanged).
// MAX_DIM caps the configured image width and height.
`default_nettype none

`include "assert_macros.svh"

module inset_glow_pixel_blend #(
  parameter int unsigned MAX_DIM = igpb_pkg::MAX_DIM_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [igpb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [igpb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [11:0]                      pos_x_i,
  input  wire logic [11:0]                      pos_y_i,
  input  wire logic [7:0]                       in_alpha_i,
  input  wire logic [7:0]                       in_red_i,
  input  wire logic [7:0]                       in_green_i,
  input  wire logic [7:0]                       in_blue_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic [7:0]                       out_alpha_o,
  output      logic [7:0]                       out_red_o,
  output      logic [7:0]                       out_green_o,
  output      logic [7:0]                       out_blue_o
);

  igpb_pkg::cfg_t cfg;
  igpb_pkg::pix_t pix_in, pix_out;
  igpb_pkg::geo_t geo;
  igpb_pkg::wt_t  wt;
  logic           geo_vld, geo_stall;
  logic           wt_vld, wt_stall;

  assign pix_in.alpha = in_alpha_i;
  assign pix_in.red   = in_red_i;
  assign pix_in.green = in_green_i;
  assign pix_in.blue  = in_blue_i;

  // register file
  igpb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // edge distance and band test
  igpb_geom #(
    .MAX_DIM (MAX_DIM)
  ) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pix_i       (pix_in),
    .out_valid_o (geo_vld),
    .out_stall_i (geo_stall),
    .out_o       (geo)
  );

  // falloff weight
  igpb_weight u_weight (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (geo_vld),
    .in_stall_o  (geo_stall),
    .in_i        (geo),
    .out_valid_o (wt_vld),
    .out_stall_i (wt_stall),
    .out_o       (wt)
  );

  // screen blend and output register
  igpb_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (wt_vld),
    .in_stall_o  (wt_stall),
    .in_i        (wt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (pix_out)
  );

  assign out_alpha_o = pix_out.alpha;
  assign out_red_o   = pix_out.red;
  assign out_green_o = pix_out.green;
  assign out_blue_o  = pix_out.blue;

  // input backs up only when the whole pipe is full and blocked
  `IGPB_ASSERT_IMPLY(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled with room in the pipe")

  // falloff weight never exceeds one half
  `IGPB_ASSERT_IMPLY(a_weight_range, clk_i, rst_ni, wt_vld, wt.k <= igpb_pkg::K_MAX, "glow weight out of range")

endmodule

`default_nettype wire

@@ rtl/igpb_cfg.sv @@
`default_nettype none

module igpb_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [igpb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [igpb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output igpb_pkg::cfg_t                        cfg_o
);

  igpb_pkg::cfg_t cfg_q;
  igpb_pkg::cfg_t cfg_d;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        igpb_pkg::REG_IMAGE_WIDTH:   cfg_d.image_width   = cfg_data_i[12:0];
        igpb_pkg::REG_IMAGE_HEIGHT:  cfg_d.image_height  = cfg_data_i[12:0];
        igpb_pkg::REG_GLOW_RED:      cfg_d.glow_red      = cfg_data_i[7:0];
        igpb_pkg::REG_GLOW_GREEN:    cfg_d.glow_green    = cfg_data_i[7:0];
        igpb_pkg::REG_GLOW_BLUE:     cfg_d.glow_blue     = cfg_data_i[7:0];
        igpb_pkg::REG_GLOW_STRENGTH: cfg_d.glow_strength = cfg_data_i[8:0];
        igpb_pkg::REG_INVERSE_BLUR:  cfg_d.inverse_blur  = cfg_data_i[23:0];
        igpb_pkg::REG_BLUR_CEILING:  cfg_d.blur_ceiling  = cfg_data_i[12:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // dims reset to one, everything else to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q               <= '0;
      cfg_q.image_width   <= 13'd1;
      cfg_q.image_height  <= 13'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/igpb_geom.sv @@
`default_nettype none

module igpb_geom #(
  parameter int unsigned MAX_DIM = igpb_pkg::MAX_DIM_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire igpb_pkg::cfg_t  cfg_i,
  input  wire logic            in_valid_i,
  output      logic            in_stall_o,
  input  wire logic [11:0]     pos_x_i,
  input  wire logic [11:0]     pos_y_i,
  input  wire igpb_pkg::pix_t  pix_i,
  output      logic            out_valid_o,
  input  wire logic            out_stall_i,
  output igpb_pkg::geo_t       out_o
);

  localparam logic [16:0] MaxDimW = 17'(MAX_DIM);

  logic        en1, en2;
  logic        vld1_q, vld2_q;
  logic [12:0] w, h, x13, y13, dx, dy, band;
  logic        glow1;

  logic           glow1_q;
  logic [12:0]    dx_q, dy_q, band_q;
  igpb_pkg::pix_t pix1_q;

  logic [12:0]    d13;
  igpb_pkg::geo_t out_d, out_q;

  assign en2        = !vld2_q || !out_stall_i;
  assign en1        = !vld1_q || en2;
  assign in_stall_o = !en1;

  // stage 1: clamp dims, per-axis edge distance, band width
  always_comb begin
    w    = (17'(cfg_i.image_width) > MaxDimW) ? MaxDimW[12:0] : cfg_i.image_width;
    h    = (17'(cfg_i.image_height) > MaxDimW) ? MaxDimW[12:0] : cfg_i.image_height;
    x13  = {1'b0, pos_x_i};
    y13  = {1'b0, pos_y_i};
    dx   = igpb_pkg::umin13(x13, w - 13'd1 - x13);
    dy   = igpb_pkg::umin13(y13, h - 13'd1 - y13);
    band = igpb_pkg::umin13(cfg_i.blur_ceiling,
                            igpb_pkg::umin13(w >> 1, h >> 1));
    glow1 = (cfg_i.glow_strength != 9'd0) && (cfg_i.inverse_blur != 24'd0) &&
            (x13 < w) && (y13 < h);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en1) begin
      vld1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      glow1_q <= glow1;
      dx_q    <= dx;
      dy_q    <= dy;
      band_q  <= band;
      pix1_q  <= pix_i;
    end
  end

  // stage 2: nearest edge and band test
  always_comb begin
    d13             = igpb_pkg::umin13(dx_q, dy_q);
    out_d.pix       = pix1_q;
    out_d.glow      = glow1_q && (d13 < band_q);
    out_d.edge_dist = d13[11:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en2) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && vld1_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld2_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

@@ rtl/igpb_weight.sv @@
`default_nettype none

module igpb_weight (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire igpb_pkg::cfg_t  cfg_i,
  input  wire logic            in_valid_i,
  output      logic            in_stall_o,
  input  wire igpb_pkg::geo_t  in_i,
  output      logic            out_valid_o,
  input  wire logic            out_stall_i,
  output igpb_pkg::wt_t        out_o
);

  logic en1, en2, en3, en4;
  logic vld1_q, vld2_q, vld3_q, vld4_q;

  logic           glow1_q, glow2_q, glow3_q;
  igpb_pkg::pix_t pix1_q, pix2_q, pix3_q;
  logic [36:0]    num_q;
  logic [16:0]    t17_d, t17_q;
  logic [33:0]    sq_q;
  logic [8:0]     s;
  logic [42:0]    ksum;
  igpb_pkg::wt_t  out_d, out_q;

  assign en4        = !vld4_q || !out_stall_i;
  assign en3        = !vld3_q || en4;
  assign en2        = !vld2_q || en3;
  assign en1        = !vld1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      if (en1) vld1_q <= in_valid_i;
      if (en2) vld2_q <= vld1_q;
      if (en3) vld3_q <= vld2_q;
      if (en4) vld4_q <= vld3_q;
    end
  end

  // stage 1: (2d+1) * inverse blur
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      num_q   <= 37'({in_i.edge_dist, 1'b1}) * 37'(cfg_i.inverse_blur);
      glow1_q <= in_i.glow;
      pix1_q  <= in_i.pix;
    end
  end

  // stage 2: t = 1 - num, zero once num reaches one
  always_comb begin
    if (num_q[36:17] == 20'd0) begin
      t17_d = 17'(igpb_pkg::T_ONE - {1'b0, num_q[16:0]});
    end else begin
      t17_d = 17'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && vld1_q) begin
      t17_q   <= t17_d;
      glow2_q <= glow1_q;
      pix2_q  <= pix1_q;
    end
  end

  // stage 3: t squared
  always_ff @(posedge clk_i) begin
    if (en3 && vld2_q) begin
      sq_q    <= 34'(t17_q) * 34'(t17_q);
      glow3_q <= glow2_q;
      pix3_q  <= pix2_q;
    end
  end

  // stage 4: scale by strength and round to the weight
  always_comb begin
    s = (cfg_i.glow_strength > igpb_pkg::STRENGTH_FULL) ? igpb_pkg::STRENGTH_FULL
                                                       : cfg_i.glow_strength;
    ksum      = 43'(s) * 43'(sq_q) + igpb_pkg::K_ROUND;
    out_d.pix = pix3_q;
    out_d.k   = glow3_q ? ksum[42:35] : 8'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en4 && vld3_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld4_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

@@ rtl/igpb_blend.sv @@
`default_nettype none

module igpb_blend (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire igpb_pkg::cfg_t  cfg_i,
  input  wire logic            in_valid_i,
  output      logic            in_stall_o,
  input  wire igpb_pkg::wt_t   in_i,
  output      logic            out_valid_o,
  input  wire logic            out_stall_i,
  output igpb_pkg::pix_t       out_o
);

  logic en1, en2;
  logic vld1_q, vld2_q;

  igpb_pkg::pix_t    pix1_q;
  logic signed [8:0] dr_q, dg_q, db_q;
  logic [15:0]       gkr_q, gkg_q, gkb_q;
  igpb_pkg::pix_t    out_d, out_q;

  // c + floor(diff * gk / 65536), clamped to a byte
  function automatic logic [7:0] blend_ch(input logic [7:0] c,
                                          input logic signed [8:0] diff,
                                          input logic [15:0] gk);
    logic signed [16:0] gks;
    logic signed [25:0] p;
    logic signed [10:0] r;
    gks = $signed({1'b0, gk});
    p   = diff * gks;
    r   = $signed({3'b000, c}) + $signed({p[25], p[25:16]});
    if (r < 11'sd0) begin
      return 8'd0;
    end else if (r > 11'sd255) begin
      return 8'd255;
    end
    return r[7:0];
  endfunction

  assign en2        = !vld2_q || !out_stall_i;
  assign en1        = !vld1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      if (en1) vld1_q <= in_valid_i;
      if (en2) vld2_q <= vld1_q;
    end
  end

  // stage 1: alpha minus channel, glow colour times weight
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      pix1_q <= in_i.pix;
      dr_q   <= $signed({1'b0, in_i.pix.alpha}) - $signed({1'b0, in_i.pix.red});
      dg_q   <= $signed({1'b0, in_i.pix.alpha}) - $signed({1'b0, in_i.pix.green});
      db_q   <= $signed({1'b0, in_i.pix.alpha}) - $signed({1'b0, in_i.pix.blue});
      gkr_q  <= 16'(cfg_i.glow_red) * 16'(in_i.k);
      gkg_q  <= 16'(cfg_i.glow_green) * 16'(in_i.k);
      gkb_q  <= 16'(cfg_i.glow_blue) * 16'(in_i.k);
    end
  end

  // stage 2: screen blend into the output register
  always_comb begin
    out_d.alpha = pix1_q.alpha;
    out_d.red   = blend_ch(pix1_q.red, dr_q, gkr_q);
    out_d.green = blend_ch(pix1_q.green, dg_q, gkg_q);
    out_d.blue  = blend_ch(pix1_q.blue, db_q, gkb_q);
  end

  always_ff @(posedge clk_i) begin
    if (en2 && vld1_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld2_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire
